[hw/rtl/smc_pkg.sv]
package smc_pkg;

  localparam logic [1:0] CMD_WR   = 2'd0;
  localparam logic [1:0] CMD_RD   = 2'd1;
  localparam logic [1:0] CMD_EXEC = 2'd2;

  localparam logic [5:0] OP_NOP  = 6'd0;
  localparam logic [5:0] OP_LIT  = 6'd1;
  localparam logic [5:0] OP_HALT = 6'd2;
  localparam logic [5:0] OP_DUP  = 6'd3;
  localparam logic [5:0] OP_DROP = 6'd4;
  localparam logic [5:0] OP_SWAP = 6'd5;
  localparam logic [5:0] OP_PUSH = 6'd6;
  localparam logic [5:0] OP_POP  = 6'd7;
  localparam logic [5:0] OP_PICK = 6'd8;
  localparam logic [5:0] OP_RICK = 6'd9;
  localparam logic [5:0] OP_JMP  = 6'd10;
  localparam logic [5:0] OP_JZ   = 6'd11;
  localparam logic [5:0] OP_RET  = 6'd12;
  localparam logic [5:0] OP_EQ   = 6'd13;
  localparam logic [5:0] OP_NEQ  = 6'd14;
  localparam logic [5:0] OP_GT   = 6'd15;
  localparam logic [5:0] OP_LT   = 6'd16;
  localparam logic [5:0] OP_AND  = 6'd17;
  localparam logic [5:0] OP_OR   = 6'd18;
  localparam logic [5:0] OP_XOR  = 6'd19;
  localparam logic [5:0] OP_SHR  = 6'd20;
  localparam logic [5:0] OP_SHL  = 6'd21;
  localparam logic [5:0] OP_TRU  = 6'd22;
  localparam logic [5:0] OP_FLS  = 6'd23;
  localparam logic [5:0] OP_ADD  = 6'd24;
  localparam logic [5:0] OP_SUB  = 6'd25;
  localparam logic [5:0] OP_MUL  = 6'd26;
  localparam logic [5:0] OP_DIV  = 6'd27;
  localparam logic [5:0] OP_MOD  = 6'd28;
  localparam logic [5:0] OP_LDC  = 6'd29;
  localparam logic [5:0] OP_STRC = 6'd30;
  localparam logic [5:0] OP_LDB  = 6'd31;
  localparam logic [5:0] OP_STRB = 6'd32;
  localparam logic [5:0] OP_CELL = 6'd33;
  localparam logic [5:0] OP_BYTE = 6'd34;
  localparam logic [5:0] OP_MEM  = 6'd35;
  localparam logic [5:0] OP_LDP  = 6'd36;
  localparam logic [5:0] OP_STRP = 6'd37;
  localparam logic [5:0] OP_LDR  = 6'd38;
  localparam logic [5:0] OP_STRR = 6'd39;
  localparam logic [5:0] OP_LDI  = 6'd40;
  localparam logic [5:0] OP_STRI = 6'd41;
  localparam logic [5:0] OP_KEY  = 6'd42;
  localparam logic [5:0] OP_EMIT = 6'd43;
  localparam logic [5:0] OP_CALL = 6'd44;
  localparam logic [5:0] OP_LAST = 6'd44;

  typedef enum logic [3:0] {
    S_IDLE, S_MRD, S_FETCH, S_DECODE, S_LOADED, S_RPOP, S_RCAP, S_POP,
    S_CAP1, S_CAP2, S_EXEC, S_PUSH2, S_PICK, S_ITER, S_STORE, S_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] mem_addr;
    logic [7:0]  mem_data;
    logic [7:0]  key_char;
  } in_req_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic        emit_valid;
    logic [7:0]  emit_char;
    logic        halted;
    logic        div_zero;
    logic [15:0] ip_now;
  } out_req_t;

  function automatic logic two_pop(logic [5:0] op);
    return (op == OP_SWAP) || (op == OP_JZ) || (op == OP_STRC) || (op == OP_STRB) ||
           ((op >= OP_EQ) && (op <= OP_MOD));
  endfunction

endpackage

[hw/rtl/stack_machine_core.sv]
// Forth-style dual-stack processor with private byte memory, data stack and return
// stack, each a single-port-write, registered-read RAM. One request is one command:
// a memory byte write, a memory byte read or one instruction. An instruction takes
// the cell fetch, a decode step and then the stack pops, stack pushes, memory bytes
// and result hand-off that it needs, with MUL, DIV and MOD iterating in the shared
// shift-add / restoring-divide unit. The memory byte port sets the cell load and
// store time. The result register holds one result while the next command starts.
// MEM_BYTES and STACK_DEPTH are powers of two; CELL_BITS is a multiple of eight.
module stack_machine_core #(
  parameter int CELL_BITS   = 16,
  parameter int MEM_BYTES   = 65536,
  parameter int STACK_DEPTH = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  smc_pkg::in_req_t   in_req,
  output logic               out_valid,
  input  logic               out_ready,
  output smc_pkg::out_req_t  out_req
);

  import smc_pkg::*;

  localparam int W  = CELL_BITS;
  localparam int CB = CELL_BITS / 8;
  localparam int AW = $clog2(MEM_BYTES);
  localparam int SW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(CELL_BITS + 1);

  state_t         state_r, state_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt, lim_r, lim_nxt;
  logic [AW-1:0]  maddr_r, maddr_nxt;
  logic [W-1:0]   acc_r, acc_nxt, op_r, op_nxt, a_r, a_nxt, b_r, b_nxt, p2_r, p2_nxt;
  logic [W-1:0]   x_r, x_nxt, y_r, y_nxt, z_r, z_nxt;
  logic           fop_r, fop_nxt;
  logic [15:0]    ip_r, ip_nxt;
  logic [7:0]     dp_r, dp_nxt, rp_r, rp_nxt, key_r, key_nxt;
  logic [7:0]     rd_r, rd_nxt, ec_r, ec_nxt;
  logic           ev_r, ev_nxt, hl_r, hl_nxt, dz_r, dz_nxt;
  logic           out_valid_r, out_valid_nxt;
  out_req_t       out_r, out_nxt;

  logic           mem_we;
  logic [AW-1:0]  mem_waddr, mem_raddr;
  logic [7:0]     mem_wdata, mem_rdata;
  logic           ds_we, rs_we;
  logic [SW-1:0]  ds_raddr, rs_raddr, rs_waddr;
  logic [W-1:0]   ds_rdata, rs_rdata, rs_wdata;
  logic           push_en;
  logic [W-1:0]   push_val, alu_val;
  logic [5:0]     opc, dopc;
  logic [15:0]    ip_inc;
  logic [7:0]     pick_n;
  logic [W:0]     div_t;

  smc_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_mem (
    .clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
    .raddr(mem_raddr), .rdata(mem_rdata)
  );

  smc_ram #(.WIDTH(W), .DEPTH(STACK_DEPTH)) u_dstack (
    .clk(clk), .we(ds_we), .waddr(dp_r[SW-1:0]), .wdata(push_val),
    .raddr(ds_raddr), .rdata(ds_rdata)
  );

  smc_ram #(.WIDTH(W), .DEPTH(STACK_DEPTH)) u_rstack (
    .clk(clk), .we(rs_we), .waddr(rs_waddr), .wdata(rs_wdata),
    .raddr(rs_raddr), .rdata(rs_rdata)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_req   = out_r;
  assign opc       = op_r[5:0];
  assign dopc      = acc_r[5:0];
  assign ip_inc    = ip_r + 16'(CB);
  assign pick_n    = a_r[7:0] + 8'd1;
  assign div_t     = {x_r, y_r[W-1]};

  always_comb begin
    unique case (opc)
      OP_EQ:   alu_val = (b_r == a_r) ? '1 : '0;
      OP_NEQ:  alu_val = (b_r != a_r) ? '1 : '0;
      OP_GT:   alu_val = (b_r > a_r) ? '1 : '0;
      OP_LT:   alu_val = (b_r < a_r) ? '1 : '0;
      OP_AND:  alu_val = b_r & a_r;
      OP_OR:   alu_val = b_r | a_r;
      OP_XOR:  alu_val = b_r ^ a_r;
      OP_SHR:  alu_val = b_r >> a_r;
      OP_SHL:  alu_val = b_r << a_r;
      OP_ADD:  alu_val = b_r + a_r;
      OP_SUB:  alu_val = b_r - a_r;
      default: alu_val = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      dp_r        <= '0;
      rp_r        <= '0;
      ip_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      dp_r        <= dp_nxt;
      rp_r        <= rp_nxt;
      ip_r        <= ip_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cnt_r <= cnt_nxt;
    lim_r <= lim_nxt;
    maddr_r <= maddr_nxt;
    acc_r <= acc_nxt;
    op_r <= op_nxt;
    a_r <= a_nxt;
    b_r <= b_nxt;
    p2_r <= p2_nxt;
    x_r <= x_nxt;
    y_r <= y_nxt;
    z_r <= z_nxt;
    fop_r <= fop_nxt;
    key_r <= key_nxt;
    rd_r <= rd_nxt;
    ec_r <= ec_nxt;
    ev_r <= ev_nxt;
    hl_r <= hl_nxt;
    dz_r <= dz_nxt;
    out_r <= out_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    lim_nxt = lim_r;
    maddr_nxt = maddr_r;
    acc_nxt = acc_r;
    op_nxt = op_r;
    a_nxt = a_r;
    b_nxt = b_r;
    p2_nxt = p2_r;
    x_nxt = x_r;
    y_nxt = y_r;
    z_nxt = z_r;
    fop_nxt = fop_r;
    ip_nxt = ip_r;
    dp_nxt = dp_r;
    rp_nxt = rp_r;
    key_nxt = key_r;
    rd_nxt = rd_r;
    ec_nxt = ec_r;
    ev_nxt = ev_r;
    hl_nxt = hl_r;
    dz_nxt = dz_r;
    out_nxt = out_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    mem_we = 1'b0;
    mem_waddr = maddr_r;
    mem_wdata = '0;
    mem_raddr = maddr_r;
    ds_raddr = dp_r[SW-1:0] - SW'(1);
    rs_raddr = rp_r[SW-1:0] - SW'(1);
    rs_we = 1'b0;
    rs_waddr = rp_r[SW-1:0];
    rs_wdata = '0;
    push_en = 1'b0;
    push_val = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          rd_nxt = '0;
          ec_nxt = '0;
          ev_nxt = 1'b0;
          hl_nxt = 1'b0;
          dz_nxt = 1'b0;
          key_nxt = in_req.key_char;
          cnt_nxt = '0;
          acc_nxt = '0;
          priority if (in_req.cmd == CMD_WR) begin
            mem_we = 1'b1;
            mem_waddr = in_req.mem_addr[AW-1:0];
            mem_wdata = in_req.mem_data;
            state_nxt = S_DONE;
          end else if (in_req.cmd == CMD_RD) begin
            mem_raddr = in_req.mem_addr[AW-1:0];
            state_nxt = S_MRD;
          end else if (in_req.cmd == CMD_EXEC) begin
            maddr_nxt = ip_r[AW-1:0];
            lim_nxt = CW'(CB);
            fop_nxt = 1'b1;
            state_nxt = S_FETCH;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_MRD: begin
        rd_nxt = mem_rdata;
        state_nxt = S_DONE;
      end
      S_FETCH: begin
        cnt_nxt = cnt_r + CW'(1);
        maddr_nxt = maddr_r + AW'(1);
        for (int j = 0; j < CB; j++) begin
          if (cnt_r == CW'(j + 1)) begin
            acc_nxt[8*j +: 8] = mem_rdata;
          end
        end
        if (cnt_r == lim_r) begin
          state_nxt = fop_r ? S_DECODE : S_LOADED;
        end
      end
      S_DECODE: begin
        op_nxt = acc_r;
        ip_nxt = ip_inc;
        state_nxt = S_DONE;
        if (acc_r > W'(OP_LAST)) begin
          rs_we = 1'b1;
          rs_wdata = W'(ip_inc);
          rp_nxt = rp_r + 8'd1;
          ip_nxt = 16'(acc_r);
        end else begin
          unique case (dopc)
            OP_NOP: ;
            OP_HALT: hl_nxt = 1'b1;
            OP_LIT: begin
              maddr_nxt = ip_inc[AW-1:0];
              cnt_nxt = '0;
              lim_nxt = CW'(CB);
              acc_nxt = '0;
              fop_nxt = 1'b0;
              state_nxt = S_FETCH;
            end
            OP_TRU: begin push_en = 1'b1; push_val = '1; end
            OP_FLS: begin push_en = 1'b1; push_val = '0; end
            OP_CELL: begin push_en = 1'b1; push_val = W'(CB); end
            OP_BYTE: begin push_en = 1'b1; push_val = W'(1); end
            OP_MEM: begin push_en = 1'b1; push_val = W'(MEM_BYTES); end
            OP_LDP: begin push_en = 1'b1; push_val = W'(dp_r); end
            OP_LDR: begin push_en = 1'b1; push_val = W'(rp_r); end
            OP_LDI: begin push_en = 1'b1; push_val = W'(ip_inc); end
            OP_KEY: begin push_en = 1'b1; push_val = W'(key_r); end
            OP_POP, OP_RET: state_nxt = S_RPOP;
            default: state_nxt = S_POP;
          endcase
        end
      end
      S_LOADED: begin
        push_en = 1'b1;
        push_val = acc_r;
        if (opc == OP_LIT) begin
          ip_nxt = ip_r + 16'(CB);
        end
        state_nxt = S_DONE;
      end
      S_RPOP: begin
        rp_nxt = rp_r - 8'd1;
        state_nxt = S_RCAP;
      end
      S_RCAP: begin
        if (opc == OP_POP) begin
          push_en = 1'b1;
          push_val = rs_rdata;
        end else begin
          ip_nxt = 16'(rs_rdata);
        end
        state_nxt = S_DONE;
      end
      S_POP: begin
        dp_nxt = dp_r - 8'd1;
        state_nxt = S_CAP1;
      end
      S_CAP1: begin
        a_nxt = ds_rdata;
        if (two_pop(opc)) begin
          dp_nxt = dp_r - 8'd1;
          state_nxt = S_CAP2;
        end else begin
          state_nxt = S_EXEC;
        end
      end
      S_CAP2: begin
        b_nxt = ds_rdata;
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        state_nxt = S_DONE;
        cnt_nxt = '0;
        unique case (opc)
          OP_DUP, OP_SWAP: begin
            push_en = 1'b1;
            push_val = a_r;
            p2_nxt = (opc == OP_DUP) ? a_r : b_r;
            state_nxt = S_PUSH2;
          end
          OP_DROP: ;
          OP_PUSH: begin
            rs_we = 1'b1;
            rs_wdata = a_r;
            rp_nxt = rp_r + 8'd1;
          end
          OP_PICK: begin
            ds_raddr = dp_r[SW-1:0] - pick_n[SW-1:0];
            state_nxt = S_PICK;
          end
          OP_RICK: begin
            rs_raddr = rp_r[SW-1:0] - pick_n[SW-1:0];
            state_nxt = S_PICK;
          end
          OP_JMP, OP_STRI, OP_CALL: ip_nxt = 16'(a_r);
          OP_JZ: begin
            if (b_r == '0) begin
              ip_nxt = 16'(a_r);
            end
          end
          OP_MUL: begin
            x_nxt = '0;
            y_nxt = a_r;
            z_nxt = b_r;
            state_nxt = S_ITER;
          end
          OP_DIV, OP_MOD: begin
            if (a_r == '0) begin
              dz_nxt = 1'b1;
              push_en = 1'b1;
              push_val = '0;
            end else begin
              x_nxt = '0;
              y_nxt = b_r;
              z_nxt = a_r;
              state_nxt = S_ITER;
            end
          end
          OP_LDC, OP_LDB: begin
            maddr_nxt = AW'(a_r);
            lim_nxt = (opc == OP_LDC) ? CW'(CB) : CW'(1);
            acc_nxt = '0;
            fop_nxt = 1'b0;
            state_nxt = S_FETCH;
          end
          OP_STRC, OP_STRB: begin
            maddr_nxt = AW'(a_r);
            lim_nxt = (opc == OP_STRC) ? CW'(CB) : CW'(1);
            state_nxt = S_STORE;
          end
          OP_STRP: dp_nxt = a_r[7:0];
          OP_STRR: rp_nxt = a_r[7:0];
          OP_EMIT: begin
            ev_nxt = 1'b1;
            ec_nxt = a_r[7:0];
          end
          default: begin
            push_en = 1'b1;
            push_val = alu_val;
          end
        endcase
      end
      S_PUSH2: begin
        push_en = 1'b1;
        push_val = p2_r;
        state_nxt = S_DONE;
      end
      S_PICK: begin
        push_en = 1'b1;
        push_val = (opc == OP_PICK) ? ds_rdata : rs_rdata;
        state_nxt = S_DONE;
      end
      S_ITER: begin
        if (cnt_r == CW'(W)) begin
          push_en = 1'b1;
          push_val = (opc == OP_DIV) ? y_r : x_r;
          state_nxt = S_DONE;
        end else begin
          cnt_nxt = cnt_r + CW'(1);
          if (opc == OP_MUL) begin
            x_nxt = y_r[0] ? x_r + z_r : x_r;
            y_nxt = y_r >> 1;
            z_nxt = z_r << 1;
          end else if (div_t >= {1'b0, z_r}) begin
            x_nxt = W'(div_t - {1'b0, z_r});
            y_nxt = {y_r[W-2:0], 1'b1};
          end else begin
            x_nxt = W'(div_t);
            y_nxt = {y_r[W-2:0], 1'b0};
          end
        end
      end
      S_STORE: begin
        mem_we = 1'b1;
        for (int j = 0; j < CB; j++) begin
          if (cnt_r == CW'(j)) begin
            mem_wdata = b_r[8*j +: 8];
          end
        end
        maddr_nxt = maddr_r + AW'(1);
        cnt_nxt = cnt_r + CW'(1);
        if (cnt_r == lim_r - CW'(1)) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_nxt.read_data = rd_r;
          out_nxt.emit_valid = ev_r;
          out_nxt.emit_char = ec_r;
          out_nxt.halted = hl_r;
          out_nxt.div_zero = dz_r;
          out_nxt.ip_now = ip_r;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    ds_we = push_en;
    if (push_en) begin
      dp_nxt = dp_r + 8'd1;
    end
  end

`ifndef SYNTH
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r != S_IDLE)
    else $error("accepted request did not start");

  a_done_loads_result: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DONE && !out_valid_r |=> out_valid_r && state_r == S_IDLE)
    else $error("finished request not presented");

  a_iter_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_ITER |-> cnt_r <= CW'(W))
    else $error("iteration counter overran");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_r.div_zero && (out_r.emit_valid || out_r.halted)))
    else $error("conflicting result flags");
`endif

endmodule

[hw/rtl/smc_ram.sv]
module smc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
